// ===== sv/whp_pkg.sv =====
package whp_pkg;

    // Parse phases of the chunk walker.
    typedef enum logic [2:0] {
        PH_HDR,
        PH_CHDR,
        PH_FMT,
        PH_SKIP,
        PH_PAD,
        PH_DRAIN
    } phase_t;

    // Result status codes.
    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_BAD_HEADER  = 2'd1;
    localparam logic [1:0] STATUS_UNSUPPORTED = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_CHANNELS = 2'd0;
    localparam logic [1:0] CFG_RATE     = 2'd1;
    localparam logic [1:0] CFG_BITS     = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [15:0] RESET_CHANNELS = 16'd2;
    localparam logic [31:0] RESET_RATE     = 32'd16000;
    localparam logic [15:0] RESET_BITS     = 16'd16;

    // Four-character tags, first character in the top byte.
    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    // Only the first part of a fmt chunk body carries fields we use.
    localparam logic [31:0] FMT_FILL_MAX = 32'd32;

endpackage

// ===== sv/wav_header_parser.sv =====
// Channel   Direction  Handshake              Payload
// --------  ---------  ---------------------  ----------------------------------------
// in        sink       in_valid / in_stall    data_byte, last_byte
// out       source     out_valid / out_stall  status, channels, stream_rate,
//                                             sample_bits, frame_count
// cfg       sink       cfg_we                 cfg_index, cfg_data
//
// A byte transfer is registered in the input register and parsed from there; a
// result leaves from the output register.
// One byte is taken every cycle while the output register is empty or being drained.
// in_stall rises only when a byte waits in the input register and the output
// register holds a result that is stalled.
// rst_n clears all parse state and loads the configuration reset values.
module wav_header_parser (
    input  logic        clk,
    input  logic        rst_n,
    // input byte stream
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    // result stream
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [15:0] channels,
    output logic [31:0] stream_rate,
    output logic [15:0] sample_bits,
    output logic [28:0] frame_count,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    // Configuration registers.
    logic [15:0] exp_channels_reg;
    logic [31:0] exp_rate_reg;
    logic [15:0] exp_bits_reg;

    // Input register.
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    // Parse state.
    whp_pkg::phase_t phase_reg, phase_next;
    logic [31:0] cnt_reg, cnt_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] len_reg, len_next;
    logic        hok_reg, hok_next;
    logic [15:0] seen_ch_reg, seen_ch_next;
    logic [31:0] seen_rate_reg, seen_rate_next;
    logic [15:0] seen_bits_reg, seen_bits_next;
    logic [15:0] work_ch_reg, work_ch_next;
    logic [31:0] work_rate_reg, work_rate_next;
    logic [15:0] work_bits_reg, work_bits_next;

    // Output register.
    logic        out_valid_reg;
    logic [1:0]  status_reg;
    logic [15:0] channels_reg;
    logic [31:0] rate_reg;
    logic [15:0] bits_reg;
    logic [28:0] frames_reg;

    // Result computed for the byte in the input register.
    logic        emit;
    logic [1:0]  res_status;
    logic [15:0] res_channels;
    logic [31:0] res_rate;
    logic [15:0] res_bits;
    logic [28:0] res_frames;

    logic        advance;
    logic        accept_in;
    logic        process;
    logic [31:0] cnt_inc;
    logic [31:0] fmt_fill;
    logic        data_ok;

    // The parse step may run whenever the output register can take a result.
    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = in_valid_reg && !advance;
    assign accept_in = in_valid && !in_stall;
    assign process   = in_valid_reg && advance;

    assign cnt_inc  = cnt_reg + 32'd1;
    assign fmt_fill = (len_reg < whp_pkg::FMT_FILL_MAX) ? len_reg : whp_pkg::FMT_FILL_MAX;

    // The parse step for one byte: all next-state values and the optional result.
    always_comb
    begin
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        tag_next       = tag_reg;
        len_next       = len_reg;
        hok_next       = hok_reg;
        seen_ch_next   = seen_ch_reg;
        seen_rate_next = seen_rate_reg;
        seen_bits_next = seen_bits_reg;
        work_ch_next   = work_ch_reg;
        work_rate_next = work_rate_reg;
        work_bits_next = work_bits_reg;
        emit           = 1'b0;
        res_status     = whp_pkg::STATUS_OK;
        res_channels   = '0;
        res_rate       = '0;
        res_bits       = '0;
        res_frames     = '0;
        data_ok        = 1'b0;

        case (phase_reg)
            whp_pkg::PH_HDR:
            begin
                // Bytes 0..11: RIFF magic, the file size and WAVE magic.
                tag_next = {tag_reg[23:0], in_byte_reg};
                if (cnt_reg == 32'd3 && tag_next != whp_pkg::TAG_RIFF)
                begin
                    hok_next = 1'b0;
                end
                if (cnt_reg == 32'd11)
                begin
                    if (tag_next != whp_pkg::TAG_WAVE)
                    begin
                        hok_next = 1'b0;
                    end
                    if (!hok_next)
                    begin
                        emit       = 1'b1;
                        res_status = whp_pkg::STATUS_BAD_HEADER;
                        phase_next = whp_pkg::PH_DRAIN;
                    end
                    else
                    begin
                        phase_next = whp_pkg::PH_CHDR;
                    end
                    cnt_next = '0;
                    tag_next = '0;
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end
            whp_pkg::PH_CHDR:
            begin
                // Chunk header: tag in big-endian order, then length little-endian.
                if (cnt_reg < 32'd4)
                begin
                    tag_next = {tag_reg[23:0], in_byte_reg};
                end
                else
                begin
                    len_next = len_reg | (32'(in_byte_reg) << {cnt_reg[1:0], 3'b000});
                end
                if (cnt_reg == 32'd7)
                begin
                    cnt_next = '0;
                    if (tag_next == whp_pkg::TAG_DATA)
                    begin
                        data_ok = seen_ch_reg == exp_channels_reg
                               && seen_rate_reg == exp_rate_reg
                               && seen_bits_reg == exp_bits_reg
                               && len_next != 32'd0
                               && !len_next[31];
                        emit         = 1'b1;
                        res_status   = data_ok ? whp_pkg::STATUS_OK
                                               : whp_pkg::STATUS_UNSUPPORTED;
                        res_channels = seen_ch_reg;
                        res_rate     = seen_rate_reg;
                        res_bits     = seen_bits_reg;
                        res_frames   = data_ok ? len_next[30:2] : '0;
                        phase_next   = whp_pkg::PH_DRAIN;
                    end
                    else if (tag_next == whp_pkg::TAG_FMT)
                    begin
                        work_ch_next   = '0;
                        work_rate_next = '0;
                        work_bits_next = '0;
                        if (len_next == 32'd0)
                        begin
                            // An empty fmt chunk commits all-zero values.
                            seen_ch_next   = '0;
                            seen_rate_next = '0;
                            seen_bits_next = '0;
                            phase_next     = whp_pkg::PH_CHDR;
                        end
                        else
                        begin
                            phase_next = whp_pkg::PH_FMT;
                        end
                    end
                    else
                    begin
                        phase_next = (len_next == 32'd0) ? whp_pkg::PH_CHDR
                                                         : whp_pkg::PH_SKIP;
                    end
                    tag_next = '0;
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end
            whp_pkg::PH_FMT:
            begin
                if (cnt_reg == 32'd2)
                begin
                    work_ch_next[7:0] = work_ch_reg[7:0] | in_byte_reg;
                end
                else if (cnt_reg == 32'd3)
                begin
                    work_ch_next[15:8] = work_ch_reg[15:8] | in_byte_reg;
                end
                else if (cnt_reg inside {[32'd4:32'd7]})
                begin
                    work_rate_next = work_rate_reg
                                   | (32'(in_byte_reg) << {cnt_reg[1:0], 3'b000});
                end
                else if (cnt_reg == 32'd14)
                begin
                    work_bits_next[7:0] = work_bits_reg[7:0] | in_byte_reg;
                end
                else if (cnt_reg == 32'd15)
                begin
                    work_bits_next[15:8] = work_bits_reg[15:8] | in_byte_reg;
                end
                // Commit at the end of the used part, so a cut-off chunk changes nothing.
                if (cnt_inc == fmt_fill)
                begin
                    seen_ch_next   = work_ch_next;
                    seen_rate_next = work_rate_next;
                    seen_bits_next = work_bits_next;
                end
                if (cnt_inc == len_reg)
                begin
                    cnt_next   = '0;
                    phase_next = len_reg[0] ? whp_pkg::PH_PAD : whp_pkg::PH_CHDR;
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end
            whp_pkg::PH_SKIP:
            begin
                if (cnt_inc == len_reg)
                begin
                    cnt_next   = '0;
                    phase_next = len_reg[0] ? whp_pkg::PH_PAD : whp_pkg::PH_CHDR;
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end
            whp_pkg::PH_PAD:
            begin
                phase_next = whp_pkg::PH_CHDR;
                cnt_next   = '0;
            end
            default:
            begin
                // Drain: bytes are dropped until the last one.
            end
        endcase

        // A fresh chunk header always starts from a zero length.
        if (phase_next == whp_pkg::PH_CHDR && cnt_next == 32'd0)
        begin
            len_next = '0;
        end

        if (in_last_reg)
        begin
            // End of file before a result: report what is known.
            if (!emit && phase_next != whp_pkg::PH_DRAIN)
            begin
                emit = 1'b1;
                if (phase_next == whp_pkg::PH_HDR)
                begin
                    res_status = whp_pkg::STATUS_BAD_HEADER;
                end
                else
                begin
                    res_status   = whp_pkg::STATUS_UNSUPPORTED;
                    res_channels = seen_ch_next;
                    res_rate     = seen_rate_next;
                    res_bits     = seen_bits_next;
                end
            end
            // The next byte begins a new file.
            phase_next     = whp_pkg::PH_HDR;
            cnt_next       = '0;
            tag_next       = '0;
            len_next       = '0;
            hok_next       = 1'b1;
            seen_ch_next   = '0;
            seen_rate_next = '0;
            seen_bits_next = '0;
            work_ch_next   = '0;
            work_rate_next = '0;
            work_bits_next = '0;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_channels_reg <= whp_pkg::RESET_CHANNELS;
            exp_rate_reg     <= whp_pkg::RESET_RATE;
            exp_bits_reg     <= whp_pkg::RESET_BITS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                whp_pkg::CFG_CHANNELS: exp_channels_reg <= cfg_data[15:0];
                whp_pkg::CFG_RATE:     exp_rate_reg     <= cfg_data;
                whp_pkg::CFG_BITS:     exp_bits_reg     <= cfg_data[15:0];
                default:
                begin
                    // No register at this index.
                end
            endcase
        end
    end

    // Input register valid and parse state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            phase_reg     <= whp_pkg::PH_HDR;
            cnt_reg       <= '0;
            tag_reg       <= '0;
            len_reg       <= '0;
            hok_reg       <= 1'b1;
            seen_ch_reg   <= '0;
            seen_rate_reg <= '0;
            seen_bits_reg <= '0;
            work_ch_reg   <= '0;
            work_rate_reg <= '0;
            work_bits_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept_in)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (process)
            begin
                phase_reg     <= phase_next;
                cnt_reg       <= cnt_next;
                tag_reg       <= tag_next;
                len_reg       <= len_next;
                hok_reg       <= hok_next;
                seen_ch_reg   <= seen_ch_next;
                seen_rate_reg <= seen_rate_next;
                seen_bits_reg <= seen_bits_next;
                work_ch_reg   <= work_ch_next;
                work_rate_reg <= work_rate_next;
                work_bits_reg <= work_bits_next;
            end

            if (process && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            in_byte_reg <= data_byte;
            in_last_reg <= last_byte;
        end
        if (process && emit)
        begin
            status_reg   <= res_status;
            channels_reg <= res_channels;
            rate_reg     <= res_rate;
            bits_reg     <= res_bits;
            frames_reg   <= res_frames;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign channels    = channels_reg;
    assign stream_rate = rate_reg;
    assign sample_bits = bits_reg;
    assign frame_count = frames_reg;

endmodule

// ===== sv/whp_checker.sv =====
module whp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic [15:0] channels,
    input logic [31:0] stream_rate,
    input logic [15:0] sample_bits,
    input logic [28:0] frame_count
);

    // A stalled result stays in place.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(frame_count))
        else $error("stalled result changed");

    // Input back-pressure only comes from a stalled result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled result");

    // Only an accepted file carries a frame count.
    a_frames_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != whp_pkg::STATUS_OK |-> frame_count == 29'd0)
        else $error("frame count on a rejected file");

    // A bad header reports no format values.
    a_bad_header: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == whp_pkg::STATUS_BAD_HEADER
        |-> channels == 16'd0 && stream_rate == 32'd0 && sample_bits == 16'd0)
        else $error("format values on a bad header");

endmodule

bind wav_header_parser whp_checker u_whp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .channels    (channels),
    .stream_rate (stream_rate),
    .sample_bits (sample_bits),
    .frame_count (frame_count)
);

// ===== verif/tb_wav_header_parser.sv =====
module tb_wav_header_parser;

    timeunit 1ns;
    timeprecision 1ps;

    // One report of the parser, laid out like its result port.
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] channels;
        logic [31:0] rate;
        logic [15:0] bits;
        logic [28:0] frames;
    } wav_report_t;

    // One row of the directed table. A row with a typed report states what
    // the parser must answer; every other row is judged by the predictor.
    typedef struct {
        logic [7:0]  value;
        logic        last;
        bit          typed;
        wav_report_t want;
    } stim_row_t;

    localparam wav_report_t NO_REPORT = '0;
    localparam wav_report_t BAD_HEADER_REPORT =
        '{whp_pkg::STATUS_BAD_HEADER, 16'd0, 32'd0, 16'd0, 29'd0};

    // Tags of chunks that the parser must skip.
    localparam logic [31:0] TAG_LIST = 32'h4C49_5354;
    localparam logic [31:0] TAG_FACT = 32'h6661_6374;

    localparam int NUM_SETTINGS      = 6;
    localparam int BYTES_PER_SETTING = 210;
    localparam int REPORTS_PER_SETTING = 8;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [15:0] channels;
    logic [31:0] stream_rate;
    logic [15:0] sample_bits;
    logic [28:0] frame_count;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = whp_pkg::CFG_CHANNELS;
    logic [31:0] cfg_data  = 32'd0;

    wav_header_parser dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .channels    (channels),
        .stream_rate (stream_rate),
        .sample_bits (sample_bits),
        .frame_count (frame_count),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The run is cut short here if the parser ever stops answering.
    initial
    begin
        #(5ms);
        $display("tb_wav_header_parser: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor state. The walker mirrors the parser's view of the stream;
    // the accept_* values are our copy of the three format registers.
    // ------------------------------------------------------------------
    whp_pkg::phase_t walk_phase;
    logic [31:0] walk_count;
    logic [31:0] walk_tag;
    logic [31:0] walk_len;
    logic        walk_hdr_ok;
    logic [15:0] fmt_channels;
    logic [31:0] fmt_rate;
    logic [15:0] fmt_bits;
    logic [15:0] draft_channels;
    logic [31:0] draft_rate;
    logic [15:0] draft_bits;
    logic [15:0] accept_channels = whp_pkg::RESET_CHANNELS;
    logic [31:0] accept_rate     = whp_pkg::RESET_RATE;
    logic [15:0] accept_bits     = whp_pkg::RESET_BITS;

    // Reports the parser still owes us, oldest first.
    wav_report_t pending_reports[$];
    // Bytes of the file being assembled for the next burst of transfers.
    logic [7:0]  file_bytes[$];

    int  error_count     = 0;
    int  reports_checked = 0;
    int  bytes_sent      = 0;
    int  files_sent      = 0;
    int  reports_owed    = 0;
    int  status_tally[4] = '{0, 0, 0, 0};
    bit  calm            = 1'b0;

    // Directed table: a one-byte file, a file whose first tag is wrong and
    // that drains one byte afterwards, and a file whose second tag is wrong
    // and that ends right on the byte where the header verdict falls.
    stim_row_t directed_rows[26] = '{
        '{8'h00, 1'b1, 1'b1, BAD_HEADER_REPORT},
        '{8'h52, 1'b0, 1'b0, NO_REPORT},
        '{8'h49, 1'b0, 1'b0, NO_REPORT},
        '{8'h46, 1'b0, 1'b0, NO_REPORT},
        '{8'h58, 1'b0, 1'b0, NO_REPORT},
        '{8'hFF, 1'b0, 1'b0, NO_REPORT},
        '{8'hFF, 1'b0, 1'b0, NO_REPORT},
        '{8'hFF, 1'b0, 1'b0, NO_REPORT},
        '{8'hFF, 1'b0, 1'b0, NO_REPORT},
        '{8'h57, 1'b0, 1'b0, NO_REPORT},
        '{8'h41, 1'b0, 1'b0, NO_REPORT},
        '{8'h56, 1'b0, 1'b0, NO_REPORT},
        '{8'h45, 1'b0, 1'b1, BAD_HEADER_REPORT},
        '{8'hFF, 1'b1, 1'b0, NO_REPORT},
        '{8'h52, 1'b0, 1'b0, NO_REPORT},
        '{8'h49, 1'b0, 1'b0, NO_REPORT},
        '{8'h46, 1'b0, 1'b0, NO_REPORT},
        '{8'h46, 1'b0, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, 1'b0, NO_REPORT},
        '{8'h00, 1'b0, 1'b0, NO_REPORT},
        '{8'h57, 1'b0, 1'b0, NO_REPORT},
        '{8'h41, 1'b0, 1'b0, NO_REPORT},
        '{8'h56, 1'b0, 1'b0, NO_REPORT},
        '{8'h46, 1'b1, 1'b1, BAD_HEADER_REPORT}
    };

    // Register settings, one per phase of the run. The fifth is drawn at
    // random when its phase begins; the first is the reset state.
    logic [15:0] set_channels[NUM_SETTINGS] =
        '{whp_pkg::RESET_CHANNELS, 16'h0000, 16'hFFFF, 16'd1, 16'd0,
          whp_pkg::RESET_CHANNELS};
    logic [31:0] set_rate[NUM_SETTINGS] =
        '{whp_pkg::RESET_RATE, 32'h0000_0000, 32'hFFFF_FFFF, 32'd44100, 32'd0,
          whp_pkg::RESET_RATE};
    logic [15:0] set_bits[NUM_SETTINGS] =
        '{whp_pkg::RESET_BITS, 16'h0000, 16'hFFFF, 16'd8, 16'd0, whp_pkg::RESET_BITS};

    // Return the walker to the start of a file. The registers are kept.
    function automatic void restart_walk();
        walk_phase     = whp_pkg::PH_HDR;
        walk_count     = 32'd0;
        walk_tag       = 32'd0;
        walk_len       = 32'd0;
        walk_hdr_ok    = 1'b1;
        fmt_channels   = 16'd0;
        fmt_rate       = 32'd0;
        fmt_bits       = 16'd0;
        draft_channels = 16'd0;
        draft_rate     = 32'd0;
        draft_bits     = 16'd0;
    endfunction

    // Advance the walker by one byte of the stream and say whether the
    // byte completes a report, and which.
    function automatic void parse_wav_byte(input logic [7:0] b, input logic last,
                                           output bit made, output wav_report_t rep);
        logic [31:0] fill;
        logic        fmt_ok;
        made = 1'b0;
        rep  = NO_REPORT;
        case (walk_phase)
            whp_pkg::PH_HDR:
            begin
                walk_tag = {walk_tag[23:0], b};
                if (walk_count == 32'd3 && walk_tag != whp_pkg::TAG_RIFF)
                    walk_hdr_ok = 1'b0;
                if (walk_count == 32'd11)
                begin
                    if (walk_tag != whp_pkg::TAG_WAVE)
                        walk_hdr_ok = 1'b0;
                    if (!walk_hdr_ok)
                    begin
                        rep.status = whp_pkg::STATUS_BAD_HEADER;
                        made       = 1'b1;
                        walk_phase = whp_pkg::PH_DRAIN;
                    end
                    else
                    begin
                        walk_phase = whp_pkg::PH_CHDR;
                    end
                    walk_count = 32'd0;
                    walk_tag   = 32'd0;
                end
                else
                begin
                    walk_count++;
                end
            end
            whp_pkg::PH_CHDR:
            begin
                // Four tag bytes, first character first, then a
                // little-endian length.
                if (walk_count < 32'd4)
                    walk_tag = {walk_tag[23:0], b};
                else
                    walk_len = walk_len | (32'(b) << (8 * walk_count[1:0]));
                if (walk_count == 32'd7)
                begin
                    walk_count = 32'd0;
                    if (walk_tag == whp_pkg::TAG_DATA)
                    begin
                        fmt_ok = fmt_channels == accept_channels &&
                                 fmt_rate == accept_rate &&
                                 fmt_bits == accept_bits &&
                                 walk_len != 32'd0 && !walk_len[31];
                        rep.status   = fmt_ok ? whp_pkg::STATUS_OK
                                              : whp_pkg::STATUS_UNSUPPORTED;
                        rep.channels = fmt_channels;
                        rep.rate     = fmt_rate;
                        rep.bits     = fmt_bits;
                        rep.frames   = fmt_ok ? walk_len[30:2] : 29'd0;
                        made         = 1'b1;
                        walk_phase   = whp_pkg::PH_DRAIN;
                    end
                    else if (walk_tag == whp_pkg::TAG_FMT)
                    begin
                        draft_channels = 16'd0;
                        draft_rate     = 32'd0;
                        draft_bits     = 16'd0;
                        if (walk_len == 32'd0)
                        begin
                            // An empty fmt chunk wipes what an earlier one said.
                            fmt_channels = 16'd0;
                            fmt_rate     = 32'd0;
                            fmt_bits     = 16'd0;
                            walk_phase   = whp_pkg::PH_CHDR;
                        end
                        else
                        begin
                            walk_phase = whp_pkg::PH_FMT;
                        end
                    end
                    else
                    begin
                        walk_phase = (walk_len == 32'd0) ? whp_pkg::PH_CHDR
                                                         : whp_pkg::PH_SKIP;
                    end
                    walk_tag = 32'd0;
                    if (walk_phase == whp_pkg::PH_CHDR)
                        walk_len = 32'd0;
                end
                else
                begin
                    walk_count++;
                end
            end
            whp_pkg::PH_FMT:
            begin
                fill = (walk_len < whp_pkg::FMT_FILL_MAX) ? walk_len : whp_pkg::FMT_FILL_MAX;
                case (walk_count)
                    32'd2: draft_channels[7:0] = b;
                    32'd3: draft_channels[15:8] = b;
                    32'd4, 32'd5, 32'd6, 32'd7: draft_rate[8 * walk_count[1:0] +: 8] = b;
                    32'd14: draft_bits[7:0] = b;
                    32'd15: draft_bits[15:8] = b;
                    default: ;
                endcase
                // The values count only once the useful part of the body is in;
                // a body that stops short leaves zeros in the missing fields.
                if (walk_count + 32'd1 == fill)
                begin
                    fmt_channels = draft_channels;
                    fmt_rate     = draft_rate;
                    fmt_bits     = draft_bits;
                end
                if (walk_count + 32'd1 == walk_len)
                begin
                    walk_count = 32'd0;
                    walk_phase = walk_len[0] ? whp_pkg::PH_PAD : whp_pkg::PH_CHDR;
                end
                else
                begin
                    walk_count++;
                end
            end
            whp_pkg::PH_SKIP:
            begin
                if (walk_count + 32'd1 == walk_len)
                begin
                    walk_count = 32'd0;
                    walk_phase = walk_len[0] ? whp_pkg::PH_PAD : whp_pkg::PH_CHDR;
                end
                else
                begin
                    walk_count++;
                end
            end
            whp_pkg::PH_PAD:
            begin
                walk_phase = whp_pkg::PH_CHDR;
                walk_count = 32'd0;
            end
            default: ;
        endcase

        if (walk_phase == whp_pkg::PH_CHDR && walk_count == 32'd0)
            walk_len = 32'd0;

        // A file that ends before any verdict still gets one report.
        if (last)
        begin
            if (!made && walk_phase != whp_pkg::PH_DRAIN)
            begin
                made = 1'b1;
                if (walk_phase == whp_pkg::PH_HDR)
                begin
                    rep.status = whp_pkg::STATUS_BAD_HEADER;
                end
                else
                begin
                    rep.status   = whp_pkg::STATUS_UNSUPPORTED;
                    rep.channels = fmt_channels;
                    rep.rate     = fmt_rate;
                    rep.bits     = fmt_bits;
                end
            end
            restart_walk();
        end
    endfunction

    function automatic void put_tag(input logic [31:0] tag);
        for (int i = 3; i >= 0; i--)
            file_bytes.push_back(tag[8 * i +: 8]);
    endfunction

    function automatic void put_le32(input logic [31:0] value);
        for (int i = 0; i < 4; i++)
            file_bytes.push_back(value[8 * i +: 8]);
    endfunction

    // Assemble one file. Most files are well formed with random content so
    // that the walk gets deep into the chunk list; the rest are noise, files
    // with a damaged magic, or files cut off at a random point.
    task automatic build_file();
        int unsigned pick;
        int unsigned n_chunks;
        logic [31:0] len;
        logic [31:0] tag;
        logic [7:0]  fmt_img[40];
        file_bytes.delete();
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            repeat ($urandom_range(1, 24))
                file_bytes.push_back(8'($urandom));
            return;
        end
        put_tag(whp_pkg::TAG_RIFF ^
                (($urandom_range(99) < 6) ? (32'd1 << $urandom_range(31)) : 32'd0));
        put_le32($urandom);
        put_tag(whp_pkg::TAG_WAVE ^
                (($urandom_range(99) < 6) ? (32'd1 << $urandom_range(31)) : 32'd0));

        // Leading chunks: usually a fmt chunk first, sometimes a second one
        // that overrides it, mixed with chunks that are only skipped.
        n_chunks = $urandom_range(0, 3);
        for (int k = 0; k < n_chunks; k++)
        begin
            if ((k == 0 && $urandom_range(99) < 85) || $urandom_range(99) < 30)
            begin
                pick = $urandom_range(99);
                if (pick < 50)
                    len = 32'd16;
                else if (pick < 65)
                    len = 32'd18;
                else
                    len = $urandom_range(0, 40);
                foreach (fmt_img[i])
                    fmt_img[i] = 8'($urandom);
                if ($urandom_range(99) < 80)
                    {fmt_img[3], fmt_img[2]} = accept_channels;
                if ($urandom_range(99) < 80)
                    {fmt_img[7], fmt_img[6], fmt_img[5], fmt_img[4]} = accept_rate;
                if ($urandom_range(99) < 80)
                    {fmt_img[15], fmt_img[14]} = accept_bits;
                put_tag(whp_pkg::TAG_FMT);
            end
            else
            begin
                case ($urandom_range(2))
                    0: tag = TAG_LIST;
                    1: tag = TAG_FACT;
                    default: tag = $urandom;
                endcase
                len = $urandom_range(0, 9);
                foreach (fmt_img[i])
                    fmt_img[i] = 8'($urandom);
                put_tag(tag);
            end
            put_le32(len);
            for (int i = 0; i < len; i++)
                file_bytes.push_back(fmt_img[i]);
            if (len[0])
                file_bytes.push_back(8'($urandom));
        end

        pick = $urandom_range(99);
        if (pick < 75)
        begin
            // Data chunk header; its length decides the frame count and,
            // when zero or with the top bit set, makes the file unsupported.
            pick = $urandom_range(99);
            if (pick < 10)
                len = 32'd0;
            else if (pick < 20)
                len = 32'h8000_0000 | $urandom;
            else if (pick < 25)
                len = 32'h7FFF_FFFF;
            else if (pick < 30)
                len = 32'hFFFF_FFFF;
            else if (pick < 38)
                len = $urandom_range(1, 7);
            else
                len = $urandom_range(8, 1 << 22);
            put_tag(whp_pkg::TAG_DATA);
            put_le32(len);
            repeat ($urandom_range(0, 4))
                file_bytes.push_back(8'($urandom));
        end
        else if (pick < 85)
        begin
            // A chunk too long to ever finish; the end of file closes it.
            put_tag(TAG_LIST);
            put_le32(32'h8000_0000 | $urandom);
            repeat ($urandom_range(1, 6))
                file_bytes.push_back(8'($urandom));
        end

        if ($urandom_range(99) < 12)
            file_bytes = file_bytes[0:$urandom_range(0, file_bytes.size() - 1)];
    endtask

    // Offer one byte, wait for the transfer, and file whatever report it
    // makes due. Called at a falling edge; returns at a falling edge.
    task automatic transfer_byte(input logic [7:0] value, input logic last, input bit typed,
                                 input wav_report_t want);
        bit          made;
        wav_report_t rep;
        while (!calm && $urandom_range(99) < 20)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= value;
        last_byte <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        parse_wav_byte(value, last, made, rep);
        if (typed)
        begin
            made = 1'b1;
            rep  = want;
        end
        if (made)
        begin
            pending_reports.push_back(rep);
            status_tally[rep.status]++;
            reports_owed++;
        end
        bytes_sent++;
        @(negedge clk);
    endtask

    // Hold the sender off until the parser has answered for every byte.
    task automatic wait_for_reports();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_reports.size() != 0);
    endtask

    // Load the three format registers, one write per cycle.
    task automatic program_format(input logic [15:0] ch, input logic [31:0] rate,
                                  input logic [15:0] bits);
        cfg_we          <= 1'b1;
        cfg_index       <= whp_pkg::CFG_CHANNELS;
        cfg_data        <= {16'd0, ch};
        accept_channels  = ch;
        @(negedge clk);
        cfg_index       <= whp_pkg::CFG_RATE;
        cfg_data        <= rate;
        accept_rate      = rate;
        @(negedge clk);
        cfg_index       <= whp_pkg::CFG_BITS;
        cfg_data        <= {16'd0, bits};
        accept_bits      = bits;
        @(negedge clk);
        cfg_we          <= 1'b0;
    endtask

    // Receiver: stalls at random about a fifth of the time, except in the calm phase.
    initial
    begin
        forever
        begin
            @(negedge clk);
            out_stall <= !calm && ($urandom_range(99) < 20);
        end
    end

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
            error_count++;
        end
    endtask

    // Every report that leaves the parser is held against the oldest one
    // still owed. Sampled at the rising edge, before the edge takes effect.
    always @(posedge clk)
    begin
        wav_report_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_reports.size() == 0)
            begin
                $display("%0t: unexpected report, expected none, got status %0d channels %0d rate %0d bits %0d frames %0d",
                         $time, status, channels, stream_rate, sample_bits, frame_count);
                error_count++;
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("status", 32'(want.status), 32'(status));
                check_field("channels", 32'(want.channels), 32'(channels));
                check_field("stream_rate", want.rate, stream_rate);
                check_field("sample_bits", 32'(want.bits), 32'(sample_bits));
                check_field("frame_count", 32'(want.frames), 32'(frame_count));
                reports_checked++;
            end
        end
    end

    // Main sequence: reset, the directed table, then one phase of random
    // files per register setting. Registers change only once the parser has
    // answered for everything.
    initial
    begin
        restart_walk();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            transfer_byte(directed_rows[i].value, directed_rows[i].last,
                          directed_rows[i].typed, directed_rows[i].want);
        files_sent = 3;

        for (int p = 0; p < NUM_SETTINGS; p++)
        begin
            if (p > 0)
            begin
                wait_for_reports();
                repeat (4) @(negedge clk);
                if (p == 4)
                begin
                    set_channels[p] = 16'($urandom_range(1, 8));
                    set_rate[p]     = $urandom;
                    set_bits[p]     = 16'($urandom);
                end
                program_format(set_channels[p], set_rate[p], set_bits[p]);
            end
            // One whole phase runs with neither side holding back.
            calm = (p == 2);
            while (bytes_sent < (p + 1) * BYTES_PER_SETTING ||
                   reports_owed < (p + 1) * REPORTS_PER_SETTING)
            begin
                if ($urandom_range(99) < 4)
                    wait_for_reports();
                build_file();
                foreach (file_bytes[i])
                    transfer_byte(file_bytes[i], i == file_bytes.size() - 1, 1'b0, NO_REPORT);
                files_sent++;
            end
        end

        wait_for_reports();
        repeat (8) @(negedge clk);

        $display("Covered %0d files in %0d byte transfers under %0d register settings.",
                 files_sent, bytes_sent, NUM_SETTINGS);
        $display("Checked %0d reports: %0d ok, %0d bad header, %0d unsupported; %0d mismatches.",
                 reports_checked, status_tally[whp_pkg::STATUS_OK],
                 status_tally[whp_pkg::STATUS_BAD_HEADER],
                 status_tally[whp_pkg::STATUS_UNSUPPORTED], error_count);
        if (error_count == 0)
            $display("tb_wav_header_parser: PASS");
        else
            $display("tb_wav_header_parser: FAIL");
        $finish;
    end

endmodule
